// ===== rtl/oaht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Open-address hash table package
// Shared constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package oaht_pkg;

  // Default sizing of the table and of the key.
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BYTES   = 8;

  // Fixed field widths at the ports.
  localparam int OP_W         = 2;
  localparam int KEY_CHARS_W  = 64;
  localparam int TABLE_SIZE_W = 7;
  localparam int SLOT_W       = 6;
  localparam int STATUS_W     = 3;

  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;

  // Operation codes; the unused code behaves as a lookup.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  // Per-slot state.
  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_state_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic probe_start;
    logic probe_run;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic probe_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/oaht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/oaht_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash remainder unit
// Restoring remainder of the key byte sum by the table size, one bit a cycle.
// ----------------------------------------------------------------------------
module oaht_mod #(
  parameter int SUM_W  = 11,
  parameter int SIZE_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  dividend_i,
  input  wire logic [SIZE_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [SIZE_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [SIZE_W-1:0] div_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] rem_d;
  logic [SIZE_W:0]   trial;
  logic              last_step;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[SUM_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = SIZE_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[SIZE_W-1:0];
    end
  end

  assign last_step = (cnt_q == CNT_W'(SUM_W - 1));

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/oaht_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table datapath
// Key normalization, hashing, slot and key stores, probe walk and result.
// ----------------------------------------------------------------------------
module oaht_dp #(
  parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = oaht_pkg::DEF_KEY_BYTES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire oaht_pkg::ctrl_cmd_t               cmd_i,
  output oaht_pkg::dp_stat_t                     stat_o,
  input  wire logic [oaht_pkg::OP_W-1:0]         operation_i,
  input  wire logic [oaht_pkg::KEY_CHARS_W-1:0]  key_chars_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [oaht_pkg::TABLE_SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic      [oaht_pkg::SLOT_W-1:0]       slot_o,
  output logic      [oaht_pkg::STATUS_W-1:0]     status_o
);

  import oaht_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int SUM_W  = $clog2(255 * KEY_BYTES + 1);

  logic [TABLE_SIZE_W-1:0] table_size_q;
  logic [SIZE_W-1:0]       eff_size;
  logic [KEY_W-1:0]        key_norm;
  logic [SUM_W-1:0]        key_sum;
  logic                    alive;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;

  logic              mod_done;
  logic [SIZE_W-1:0] mod_rem;

  logic [ADDR_W-1:0] issue_q;
  logic [ADDR_W-1:0] issue_nxt;
  logic [SIZE_W-1:0] issue_ext;
  logic [ADDR_W-1:0] home_q;
  logic [ADDR_W-1:0] chk_addr_q;
  logic              chk_vld_q;
  logic [SIZE_W-1:0] chk_cnt_q;
  logic              rd_stop;
  logic              last_probe;
  logic              probe_end;

  logic [ADDR_W-1:0] dec_slot_q;
  logic              dec_stop_q;
  logic [1:0]        dec_state_q;

  logic [ADDR_W-1:0] clr_addr_q;

  logic [1:0]        state_rdata;
  logic [KEY_W-1:0]  key_rdata;
  logic              state_we;
  logic [ADDR_W-1:0] state_waddr;
  logic [1:0]        state_wdata;
  logic              key_we;

  status_e           status_d;
  logic              key_we_fin;
  logic              state_we_fin;
  slot_state_e       state_wval;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [STATUS_W-1:0] status_q;

  // Table size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RESET;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  // Effective size: zero counts as one, large values clip to the depth.
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = SIZE_W'(table_size_q);
    end
  end

  // Keep the bytes before the first zero byte and sum them.
  always_comb begin
    key_norm = '0;
    key_sum  = '0;
    alive    = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (key_chars_i[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_norm[8*i +: 8] = key_chars_i[8*i +: 8];
        key_sum            = key_sum + SUM_W'(key_chars_i[8*i +: 8]);
      end
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      key_q  <= key_norm;
      size_q <= eff_size;
    end
  end

  // Home slot: byte sum modulo the table size.
  oaht_mod #(
    .SUM_W  (SUM_W),
    .SIZE_W (SIZE_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (key_sum),
    .divisor_i  (eff_size),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Next probe address with wrap at the table size.
  always_comb begin
    issue_ext = SIZE_W'(issue_q) + SIZE_W'(1);
    if (issue_ext >= size_q) begin
      issue_nxt = '0;
    end else begin
      issue_nxt = ADDR_W'(issue_ext);
    end
  end

  // Check of the slot read in the previous cycle.
  assign rd_stop    = (state_rdata == SLOT_EMPTY) || (key_rdata == key_q);
  assign last_probe = (chk_cnt_q == size_q - SIZE_W'(1));
  assign probe_end  = chk_vld_q && (rd_stop || last_probe);

  // Probe walk: one read issued and one slot checked each cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q <= 1'b0;
    end else if (cmd_i.probe_start) begin
      chk_vld_q <= 1'b0;
    end else if (cmd_i.probe_run) begin
      chk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      issue_q   <= ADDR_W'(mod_rem);
      home_q    <= ADDR_W'(mod_rem);
      chk_cnt_q <= '0;
    end else if (cmd_i.probe_run) begin
      issue_q    <= issue_nxt;
      chk_addr_q <= issue_q;
      if (chk_vld_q) begin
        chk_cnt_q <= chk_cnt_q + SIZE_W'(1);
      end
    end
    if (cmd_i.probe_run && probe_end) begin
      dec_slot_q  <= rd_stop ? chk_addr_q : home_q;
      dec_stop_q  <= rd_stop;
      dec_state_q <= state_rdata;
    end
  end

  // Result and store updates for the probed slot.
  always_comb begin
    status_d     = ST_NOT_FOUND;
    key_we_fin   = 1'b0;
    state_we_fin = 1'b0;
    state_wval   = SLOT_USED;
    if (!dec_stop_q) begin
      status_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      case (op_q)
        OP_INSERT: begin
          if (dec_state_q == SLOT_USED) begin
            status_d = ST_PRESENT;
          end else begin
            key_we_fin   = 1'b1;
            state_we_fin = 1'b1;
            state_wval   = SLOT_USED;
            status_d     = ST_INSERTED;
          end
        end
        OP_DELETE: begin
          if (dec_state_q == SLOT_USED) begin
            state_we_fin = 1'b1;
            state_wval   = SLOT_DELETED;
            status_d     = ST_DELETED;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          status_d = (dec_state_q == SLOT_USED) ? ST_FOUND : ST_NOT_FOUND;
        end
      endcase
    end
  end

  // Clearing pass over the slot states after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end

  // Store write ports.
  assign state_we    = cmd_i.clr_step || (cmd_i.finish && state_we_fin);
  assign state_waddr = cmd_i.clr_step ? clr_addr_q : dec_slot_q;
  assign state_wdata = cmd_i.clr_step ? SLOT_EMPTY : state_wval;
  assign key_we      = cmd_i.finish && key_we_fin;

  oaht_ram #(
    .WIDTH (2),
    .DEPTH (TABLE_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (state_we),
    .waddr_i (state_waddr),
    .wdata_i (state_wdata),
    .raddr_i (issue_q),
    .rdata_o (state_rdata)
  );

  oaht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (dec_slot_q),
    .wdata_i (key_q),
    .raddr_i (issue_q),
    .rdata_o (key_rdata)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      slot_q   <= SLOT_W'(dec_slot_q);
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign status_o    = status_q;

  // Status toward the controller.
  assign stat_o.clr_last  = (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1));
  assign stat_o.mod_done  = mod_done;
  assign stat_o.probe_end = probe_end;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// ===== rtl/oaht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table controller
// Sequences clearing, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire oaht_pkg::dp_stat_t  stat_i,
  output oaht_pkg::ctrl_cmd_t      cmd_o
);

  import oaht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  // Commands decoded from the state and the datapath status.
  always_comb begin
    cmd_o             = '0;
    cmd_o.clr_step    = (state_q == S_CLEAR);
    cmd_o.load        = in_ready_q && in_valid_i;
    cmd_o.probe_start = (state_q == S_HASH) && stat_i.mod_done;
    cmd_o.probe_run   = (state_q == S_PROBE);
    cmd_o.finish      = (state_q == S_RESP) && stat_i.out_free;
  end

  // State and ready register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clr_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_HASH;
            in_ready_q <= 1'b0;
          end
        end
        S_HASH: begin
          if (stat_i.mod_done) begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (stat_i.probe_end) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (stat_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule
`default_nettype wire

// ===== rtl/open_address_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Open-address hash table
// String-key table with linear probing: insert, delete and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per request (operation and key bytes);
//   the output channel returns one beat per request with the slot where the
//   probe stopped (the home slot if no slot stopped it) and a status code.
//   Both channels use valid/ready. The table size register is written
//   through cfg_we_i/cfg_wdata_i; the user must write it only while the
//   block is idle, which the block itself does not enforce. It resets to 64
//   slots. The home slot comes from a bit-serial remainder unit (one bit a
//   cycle) over the key byte sum, which is SUM_W bits wide (11 bits for
//   8-byte keys); the probe walk then checks one slot a cycle through the
//   registered read port of the stores.
//   One request is in flight at a time; the next beat is accepted the cycle
//   after the result is loaded into the output register, even while that
//   result still waits.
//   If the receiver stalls with a result pending, the finished request holds
//   until the output register frees up.
//   After reset all TABLE_DEPTH slot states (64 by default) are cleared, one
//   slot a cycle; input ready stays low meanwhile.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
  parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = oaht_pkg::DEF_KEY_BYTES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [oaht_pkg::TABLE_SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [oaht_pkg::OP_W-1:0]         operation_i,
  input  wire logic [oaht_pkg::KEY_CHARS_W-1:0]  key_chars_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [oaht_pkg::SLOT_W-1:0]       slot_o,
  output logic      [oaht_pkg::STATUS_W-1:0]     status_o
);

  import oaht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  oaht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath with the slot and key stores.
  oaht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation_i),
    .key_chars_i (key_chars_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .slot_o      (slot_o),
    .status_o    (status_o)
  );

endmodule
`default_nettype wire
